// ===== sv/xsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xsd_pkg;

    // Default geometry of the display
    localparam int unsigned FB_WIDTH_DEF        = 64;
    localparam int unsigned FB_HEIGHT_DEF       = 32;
    localparam int unsigned MAX_SPRITE_ROWS_DEF = 16;

    // Fixed field widths
    localparam int unsigned PIX_W     = 64;   // one framebuffer row
    localparam int unsigned COORD_W   = 8;    // x_pos / y_pos
    localparam int unsigned OFF_W     = 4;    // row_offset
    localparam int unsigned BYTE_W    = 8;    // sprite_byte
    localparam int unsigned ROW_IDX_W = 6;    // holds any row of the tallest display
    localparam int unsigned COL_W     = 6;    // holds any column of the widest display

    // Item opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Coordinate reduction table: entry i holds i mod the given size
    typedef logic [(1 << COORD_W) - 1:0][COL_W-1:0] mod_tbl_t;

    // Decoded item passed from the front end to the draw unit
    typedef struct packed {
        logic [1:0]           kind;
        logic [ROW_IDX_W-1:0] row_idx;
        logic                 in_range;
        logic [PIX_W-1:0]     mask;
        logic                 first_row;
        logic                 last_row;
    } xsd_cmd_t;

    // Build the mod table by counting, wrapping at the modulus
    function automatic mod_tbl_t build_mod_table(input int unsigned modulus);
        mod_tbl_t    tbl;
        int unsigned r;
        r = 0;
        for (int unsigned i = 0; i < (1 << COORD_W); i++) begin
            tbl[i] = COL_W'(r);
            if (r + 1 == modulus) begin
                r = 0;
            end else begin
                r = r + 1;
            end
        end
        return tbl;
    endfunction

endpackage

`default_nettype wire

// ===== sv/xsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xsd_front
    import xsd_pkg::*;
#(
    parameter int unsigned FB_WIDTH        = FB_WIDTH_DEF,
    parameter int unsigned FB_HEIGHT       = FB_HEIGHT_DEF,
    parameter int unsigned MAX_SPRITE_ROWS = MAX_SPRITE_ROWS_DEF
) (
    input  wire logic [1:0]         opcode,
    input  wire logic [COORD_W-1:0] x_pos,
    input  wire logic [COORD_W-1:0] y_pos,
    input  wire logic [OFF_W-1:0]   row_offset,
    input  wire logic [BYTE_W-1:0]  sprite_byte,
    input  wire logic               first_row,
    input  wire logic               last_row,
    output xsd_cmd_t                cmd
);

    localparam int unsigned ROW_W  = $clog2(FB_HEIGHT);
    localparam int unsigned SUM_W  = $clog2(FB_HEIGHT + (1 << OFF_W));
    localparam int unsigned MAXR_W = ($clog2(MAX_SPRITE_ROWS + 1) > OFF_W) ?
                                     $clog2(MAX_SPRITE_ROWS + 1) : OFF_W;

    localparam mod_tbl_t         X_TBL     = build_mod_table(FB_WIDTH);
    localparam mod_tbl_t         Y_TBL     = build_mod_table(FB_HEIGHT);
    localparam logic [PIX_W-1:0] EDGE_MASK = ~({PIX_W{1'b1}} >> FB_WIDTH);

    logic [COL_W-1:0] x_mod;
    logic [ROW_W-1:0] y_mod;
    logic [SUM_W-1:0] row_sum;
    logic             off_ok;
    logic             row_ok;
    logic [PIX_W-1:0] shifted;

    // Reduce coordinates to the display
    assign x_mod   = X_TBL[x_pos];
    assign y_mod   = Y_TBL[y_pos][ROW_W-1:0];
    assign row_sum = SUM_W'(y_mod) + SUM_W'(row_offset);
    assign off_ok  = MAXR_W'(row_offset) < MAXR_W'(MAX_SPRITE_ROWS);
    assign row_ok  = row_sum < SUM_W'(FB_HEIGHT);

    // Place the byte at the start column; bits past the right edge fall off
    assign shifted = {sprite_byte, {(PIX_W - BYTE_W){1'b0}}} >> x_mod;

    // Classify the item
    always_comb begin
        cmd           = '0;
        cmd.kind      = opcode;
        cmd.first_row = first_row;
        cmd.last_row  = last_row;
        cmd.mask      = shifted & EDGE_MASK;
        case (opcode)
            OP_DRAW: begin
                cmd.row_idx  = ROW_IDX_W'(row_sum[ROW_W-1:0]);
                cmd.in_range = off_ok && row_ok;
            end
            OP_READ: begin
                cmd.row_idx  = ROW_IDX_W'(y_mod);
                cmd.in_range = 1'b1;
            end
            default: begin
                cmd.row_idx  = '0;
                cmd.in_range = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/xsd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xsd_queue
    import xsd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire xsd_cmd_t in_cmd,
    output logic          out_valid,
    input  wire logic     out_ready,
    output xsd_cmd_t      out_cmd
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    xsd_cmd_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Track fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // Hold item payloads
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/xsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xsd_back
    import xsd_pkg::*;
#(
    parameter int unsigned FB_HEIGHT = FB_HEIGHT_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire xsd_cmd_t   cmd,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_collision,
    output logic [PIX_W-1:0] m_row_pixels,
    output logic            m_sprite_done
);

    localparam int unsigned ROW_W = $clog2(FB_HEIGHT);

    // Framebuffer rows and their written marks
    logic [PIX_W-1:0]     frame_mem [FB_HEIGHT];
    logic [FB_HEIGHT-1:0] row_valid_reg;

    // Read stage
    logic                 b_valid_reg;
    xsd_cmd_t             b_cmd_reg;
    logic [PIX_W-1:0]     rd_data_reg;

    // Last row written, for forwarding
    logic                 lw_valid_reg;
    logic [ROW_W-1:0]     lw_row_reg;
    logic [PIX_W-1:0]     lw_data_reg;

    logic                 coll_reg;
    logic                 coll_next;

    // Output register
    logic                 m_valid_reg;
    logic                 m_collision_reg;
    logic [PIX_W-1:0]     m_row_pixels_reg;
    logic                 m_sprite_done_reg;

    logic                 b_adv;
    logic                 pop;
    logic [ROW_W-1:0]     q_row;
    logic [ROW_W-1:0]     b_row;
    logic                 fwd_hit;
    logic [PIX_W-1:0]     old_row;
    logic [PIX_W-1:0]     new_row;
    logic                 draw_hit;
    logic                 is_clear;
    logic [PIX_W-1:0]     pixels;
    logic                 done;

    assign b_adv     = b_valid_reg && (!m_valid_reg || m_ready);
    assign cmd_ready = !b_valid_reg || b_adv;
    assign pop       = cmd_valid && cmd_ready;
    assign q_row     = cmd.row_idx[ROW_W-1:0];
    assign b_row     = b_cmd_reg.row_idx[ROW_W-1:0];

    // Pick the current row contents: forwarded write, stored row, or cleared
    assign fwd_hit = lw_valid_reg && (lw_row_reg == b_row);
    always_comb begin
        if (fwd_hit) begin
            old_row = lw_data_reg;
        end else if (row_valid_reg[b_row]) begin
            old_row = rd_data_reg;
        end else begin
            old_row = '0;
        end
    end

    assign new_row = old_row ^ b_cmd_reg.mask;

    // Carry out the item
    always_comb begin
        draw_hit  = 1'b0;
        is_clear  = 1'b0;
        pixels    = '0;
        done      = 1'b0;
        coll_next = coll_reg;
        case (b_cmd_reg.kind)
            OP_CLEAR: begin
                is_clear = 1'b1;
            end
            OP_DRAW: begin
                draw_hit = b_cmd_reg.in_range;
                done     = b_cmd_reg.last_row;
                if (b_cmd_reg.first_row) begin
                    coll_next = 1'b0;
                end
                if (draw_hit) begin
                    pixels = new_row;
                    if ((old_row & b_cmd_reg.mask) != '0) begin
                        coll_next = 1'b1;
                    end
                end
            end
            OP_READ: begin
                pixels = old_row;
            end
            default: begin
                pixels = '0;
            end
        endcase
    end

    // Read the row on pop, write it back when the item leaves
    always_ff @(posedge aclk) begin
        if (pop) begin
            rd_data_reg <= frame_mem[q_row];
            b_cmd_reg   <= cmd;
        end
        if (b_adv && draw_hit) begin
            frame_mem[b_row] <= new_row;
            lw_row_reg       <= b_row;
            lw_data_reg      <= new_row;
        end
        if (b_adv) begin
            m_collision_reg   <= coll_next;
            m_row_pixels_reg  <= pixels;
            m_sprite_done_reg <= done;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
            lw_valid_reg  <= 1'b0;
            coll_reg      <= 1'b0;
        end else begin
            if (pop) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                coll_reg <= coll_next;
                if (is_clear) begin
                    row_valid_reg <= '0;
                    lw_valid_reg  <= 1'b0;
                end else if (draw_hit) begin
                    row_valid_reg[b_row] <= 1'b1;
                    lw_valid_reg         <= 1'b1;
                end
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_collision   = m_collision_reg;
    assign m_row_pixels  = m_row_pixels_reg;
    assign m_sprite_done = m_sprite_done_reg;

endmodule

`default_nettype wire

// ===== sv/xor_sprite_draw_engine.sv =====
// Channel   Ports                                          Direction
// s_        s_valid/s_ready, s_opcode, s_x_pos, s_y_pos,   in
//           s_row_offset, s_sprite_byte, s_first_row,
//           s_last_row
// m_        m_valid/m_ready, m_collision, m_row_pixels,    out
//           m_sprite_done
//
// One item per cycle sustained while m_ready stays high; an accepted item passes the queue
// slot, framebuffer read and output register before a result is offered. Each draw row is a
// read-modify-write of one framebuffer row, with the last write forwarded to the next item.
// Reset and clear items wipe the framebuffer at once through per-row written marks.
// A two-entry queue separates decode from the draw unit, so input stays open while
// a result waits on m_ready, until both queue entries are full.
`timescale 1ns / 1ps
`default_nettype none

module xor_sprite_draw_engine
    import xsd_pkg::*;
#(
    parameter int unsigned FB_WIDTH        = FB_WIDTH_DEF,
    parameter int unsigned FB_HEIGHT       = FB_HEIGHT_DEF,
    parameter int unsigned MAX_SPRITE_ROWS = MAX_SPRITE_ROWS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_opcode,
    input  wire logic [COORD_W-1:0] s_x_pos,
    input  wire logic [COORD_W-1:0] s_y_pos,
    input  wire logic [OFF_W-1:0]   s_row_offset,
    input  wire logic [BYTE_W-1:0]  s_sprite_byte,
    input  wire logic               s_first_row,
    input  wire logic               s_last_row,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_collision,
    output logic [PIX_W-1:0]        m_row_pixels,
    output logic                    m_sprite_done
);

    xsd_cmd_t front_cmd;
    xsd_cmd_t q_cmd;
    logic     q_valid;
    logic     q_ready;

    // Decode incoming items
    xsd_front #(
        .FB_WIDTH        (FB_WIDTH),
        .FB_HEIGHT       (FB_HEIGHT),
        .MAX_SPRITE_ROWS (MAX_SPRITE_ROWS)
    ) u_front (
        .opcode      (s_opcode),
        .x_pos       (s_x_pos),
        .y_pos       (s_y_pos),
        .row_offset  (s_row_offset),
        .sprite_byte (s_sprite_byte),
        .first_row   (s_first_row),
        .last_row    (s_last_row),
        .cmd         (front_cmd)
    );

    // Buffer decoded items
    xsd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (front_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    // Apply items to the framebuffer
    xsd_back #(
        .FB_HEIGHT (FB_HEIGHT)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (q_valid),
        .cmd_ready     (q_ready),
        .cmd           (q_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_collision   (m_collision),
        .m_row_pixels  (m_row_pixels),
        .m_sprite_done (m_sprite_done)
    );

endmodule

`default_nettype wire
